### rtl/wfc_pkg.sv
// shared types, constants and helpers of the word frequency counter
package wfc_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int WORD_CHARS_DEF    = 16;
    localparam int CHAR_W            = 8;
    localparam int COUNT_W           = 16;
    localparam int INDEX_W           = 6;

    localparam logic [CHAR_W-1:0]  SPACE_BYTE = 8'd32;
    localparam logic [CHAR_W-1:0]  UPPER_A    = 8'd65;
    localparam logic [CHAR_W-1:0]  UPPER_Z    = 8'd90;
    localparam logic [CHAR_W-1:0]  CASE_SHIFT = 8'd32;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [INDEX_W-1:0] entry_index;
        logic [COUNT_W-1:0] word_total;
        logic               new_entry;
        logic               table_full;
        logic               word_truncated;
    } t_out_item;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_CMP,
        BK_MISS,
        BK_DONE
    } t_back_state;

    function automatic logic [CHAR_W-1:0] fold_byte(input logic [CHAR_W-1:0] b);
        logic [CHAR_W-1:0] r;
        r = b;
        if (b >= UPPER_A && b <= UPPER_Z) begin
            r = b + CASE_SHIFT;
        end
        return r;
    endfunction

endpackage

### rtl/wfc_ram.sv
// generic single-write, single-read ram with registered read data
module wfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/wfc_queue.sv
// two-entry command queue between the byte front end and the table engine
module wfc_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_slot [2];
    logic             r_wptr, r_rptr;
    logic [1:0]       r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_slot[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

endmodule

### rtl/wfc_front.sv
// byte front end: folds case, collects the open word, emits close/clear commands
module wfc_front import wfc_pkg::*; #(
    parameter int WORD_CHARS = WORD_CHARS_DEF,
    parameter int CMD_W      = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  t_in_item         i_item,
    output logic             o_cmd_push,
    output logic [CMD_W-1:0] o_cmd
);

    localparam int LW = $clog2(WORD_CHARS + 1);
    localparam int IW = $clog2(WORD_CHARS);
    localparam logic [LW-1:0] W_LEN = LW'(WORD_CHARS);

    logic [CHAR_W-1:0] r_chars [WORD_CHARS];
    logic [CHAR_W-1:0] n_chars [WORD_CHARS];
    logic [LW-1:0]     r_len, n_len;
    logic              r_ovf, n_ovf;
    logic              is_space, close_word;
    logic [WORD_CHARS*CHAR_W-1:0] packed_chars;

    always_comb begin
        is_space = (i_item.text_byte == SPACE_BYTE);
        n_chars  = r_chars;
        n_len    = r_len;
        n_ovf    = r_ovf;
        if (!is_space) begin
            if (r_len < W_LEN) begin
                n_chars[r_len[IW-1:0]] = fold_byte(i_item.text_byte);
                n_len = r_len + LW'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
        close_word = (is_space || i_item.end_of_text) && (n_len != '0);
        for (int i = 0; i < WORD_CHARS; i++) begin
            packed_chars[i*CHAR_W +: CHAR_W] = n_chars[i];
        end
    end

    // command: clear, word present, truncated, length, characters
    assign o_cmd      = {i_item.end_of_text, close_word, n_ovf, n_len, packed_chars};
    assign o_cmd_push = i_accept && (close_word || i_item.end_of_text);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_ovf <= 1'b0;
        end else if (i_accept) begin
            if (close_word || i_item.end_of_text) begin
                r_len <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_len <= n_len;
                r_ovf <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_chars <= n_chars;
        end
    end

endmodule

### rtl/wfc_back.sv
// table engine: linear search over stored words, count update, insert, or drop when the table is full
module wfc_back import wfc_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int WORD_CHARS    = WORD_CHARS_DEF,
    parameter int CMD_W         = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  logic [CMD_W-1:0] i_cmd,
    output logic             o_cmd_pop,
    output logic             o_res_valid,
    output t_out_item        o_res,
    input  logic             i_res_pop
);

    localparam int LW    = $clog2(WORD_CHARS + 1);
    localparam int TW    = WORD_CHARS * CHAR_W;
    localparam int AW    = $clog2(TABLE_ENTRIES);
    localparam int UW    = $clog2(TABLE_ENTRIES + 1);
    localparam int ROW_W = COUNT_W + LW + TW;
    localparam logic [UW-1:0] T_FULL = UW'(TABLE_ENTRIES);

    t_back_state      r_state, n_state;
    logic [CMD_W-1:0] r_cmd, n_cmd;
    logic [AW-1:0]    r_slot, n_slot;
    logic [UW-1:0]    r_used, n_used;
    t_out_item        r_res, n_res, r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic             cmd_clear, cmd_ovf;
    logic [LW-1:0]    cmd_len;
    logic [TW-1:0]    cmd_chars;

    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr;
    logic [ROW_W-1:0] ram_wdata, ram_rdata;
    logic [COUNT_W-1:0] row_count, inc_count;
    logic [LW-1:0]    row_len;
    logic [TW-1:0]    row_chars;
    logic             hit;

    assign cmd_clear = r_cmd[CMD_W-1];
    assign cmd_ovf   = r_cmd[CMD_W-3];
    assign cmd_len   = r_cmd[TW +: LW];
    assign cmd_chars = r_cmd[TW-1:0];

    assign {row_count, row_len, row_chars} = ram_rdata;
    assign inc_count = (row_count == COUNT_MAX) ? COUNT_MAX : row_count + COUNT_W'(1);

    // only the first length characters take part in the match
    always_comb begin
        hit = (row_len == cmd_len);
        for (int i = 0; i < WORD_CHARS; i++) begin
            if (LW'(i) < cmd_len &&
                row_chars[i*CHAR_W +: CHAR_W] != cmd_chars[i*CHAR_W +: CHAR_W]) begin
                hit = 1'b0;
            end
        end
    end

    wfc_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_ENTRIES)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_slot      = r_slot;
        n_used      = r_used;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_res_pop;
        o_cmd_pop   = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = r_slot;
        ram_wdata   = {row_count, row_len, row_chars};
        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_slot    = '0;
                    if (!i_cmd[CMD_W-2]) begin
                        n_used = '0;
                    end else if (r_used == '0) begin
                        n_state = BK_MISS;
                    end else begin
                        n_state = BK_READ;
                    end
                end
            end
            BK_READ: begin
                ram_re  = 1'b1;
                n_state = BK_CMP;
            end
            BK_CMP: begin
                if (hit) begin
                    ram_we    = 1'b1;
                    ram_wdata = {inc_count, row_len, row_chars};
                    n_res     = '{entry_index: INDEX_W'(r_slot), word_total: inc_count,
                                  new_entry: 1'b0, table_full: 1'b0,
                                  word_truncated: cmd_ovf};
                    n_state   = BK_DONE;
                end else if (UW'(r_slot) == r_used - UW'(1)) begin
                    n_state = BK_MISS;
                end else begin
                    n_slot  = r_slot + AW'(1);
                    n_state = BK_READ;
                end
            end
            BK_MISS: begin
                if (r_used < T_FULL) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_used[AW-1:0];
                    ram_wdata = {COUNT_W'(1), cmd_len, cmd_chars};
                    n_res     = '{entry_index: INDEX_W'(r_used[AW-1:0]),
                                  word_total: COUNT_W'(1), new_entry: 1'b1,
                                  table_full: 1'b0, word_truncated: cmd_ovf};
                    n_used    = r_used + UW'(1);
                end else begin
                    n_res = '{entry_index: '0, word_total: '0, new_entry: 1'b0,
                              table_full: 1'b1, word_truncated: cmd_ovf};
                end
                n_state = BK_DONE;
            end
            BK_DONE: begin
                if (!r_out_valid || i_res_pop) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    if (cmd_clear) begin
                        n_used = '0;
                    end
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_slot <= n_slot;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

### rtl/word_frequency_counter_top.sv
// bytes accepted every cycle until the two-entry command queue fills
// a closed word is searched stored entry by stored entry, each read and then compared
// a hit bumps the count, a miss inserts or drops; non-closing bytes only fill the word
// the result stays on o_result until popped; the engine waits for it to be popped
// synchronous active-low reset empties the queue, the open word and the table
// table contents are not cleared; the entry count alone marks what is valid
module word_frequency_counter_top import wfc_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int WORD_CHARS    = WORD_CHARS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    input  t_in_item  i_item,
    output logic      full,
    input  logic      pop,
    output logic      empty,
    output t_out_item o_result
);

    localparam int LW    = $clog2(WORD_CHARS + 1);
    localparam int CMD_W = 3 + LW + WORD_CHARS * CHAR_W;

    logic             accept, cmd_push, q_full, q_valid, q_pop, res_valid;
    logic [CMD_W-1:0] cmd_in, cmd_out;

    assign accept = push && !q_full;
    assign full   = q_full;
    assign empty  = !res_valid;

    wfc_front #(.WORD_CHARS(WORD_CHARS), .CMD_W(CMD_W)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    wfc_queue #(.WIDTH(CMD_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (cmd_out)
    );

    wfc_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .WORD_CHARS    (WORD_CHARS),
        .CMD_W         (CMD_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (q_pop),
        .o_res_valid (res_valid),
        .o_res       (o_result),
        .i_res_pop   (pop && res_valid)
    );

endmodule

### rtl/wfc_checker.sv
// port-level checks of the word frequency counter and their bind
module wfc_checker import wfc_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      pop,
    input logic      empty,
    input t_out_item o_result
);

    // a waiting transaction stays put until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("result changed while waiting");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_result.new_entry && o_result.table_full))
        else $error("insert and drop flagged together");

    a_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.new_entry) |-> (o_result.word_total == COUNT_W'(1)))
        else $error("inserted word count not one");

    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.table_full) |->
        (o_result.word_total == '0 && o_result.entry_index == '0))
        else $error("dropped word carries index or count");

    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.word_total != '0 || o_result.table_full))
        else $error("zero count on counted word");

endmodule

bind word_frequency_counter_top wfc_checker u_wfc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .pop      (pop),
    .empty    (empty),
    .o_result (o_result)
);

### verif/word_frequency_counter_top_tb.sv
// self-checking testbench of the word frequency counter
module word_frequency_counter_top_tb;
    import wfc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS  = 64;
    localparam int MAX_CHARS  = 16;
    localparam int RAND_ITEMS = 640;
    localparam int CYCLE_LIMIT = 2_500_000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    t_in_item  i_item = '0;
    logic      full;
    logic      pop = 1'b0;
    logic      empty;
    t_out_item o_result;

    word_frequency_counter_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .i_item   (i_item),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .o_result (o_result)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state: the open word and the word table
    logic [7:0] open_chars [MAX_CHARS];
    int         open_len;
    bit         open_cut;
    logic [7:0] slot_text [NUM_SLOTS][MAX_CHARS];
    int         slot_len [NUM_SLOTS];
    int         slot_count [NUM_SLOTS];
    int         slots_used;

    t_out_item  word_results [$];
    int         fail_count;
    int         cycle_count;
    int         sender_idle_pct;
    int         receiver_stall_pct;
    int         items_sent;
    t_out_item  want;

    function automatic logic [7:0] lower_case(input logic [7:0] b);
        return (b >= 8'd65 && b <= 8'd90) ? b + 8'd32 : b;
    endfunction

    // closes the open word and queues the expected result
    function automatic bit close_open_word();
        t_out_item r;
        int        hit;
        bit        same;
        if (open_len == 0) return 1'b0;
        r = '0;
        hit = -1;
        for (int s = 0; s < slots_used && hit < 0; s++) begin
            same = (slot_len[s] == open_len);
            for (int c = 0; c < open_len && same; c++)
                if (slot_text[s][c] != open_chars[c]) same = 1'b0;
            if (same) hit = s;
        end
        if (hit >= 0) begin
            if (slot_count[hit] < 65535) slot_count[hit]++;
            r.entry_index = hit[5:0];
            r.word_total  = slot_count[hit][15:0];
        end else if (slots_used < NUM_SLOTS) begin
            for (int c = 0; c < open_len; c++) slot_text[slots_used][c] = open_chars[c];
            slot_len[slots_used]   = open_len;
            slot_count[slots_used] = 1;
            r.entry_index = slots_used[5:0];
            r.word_total  = 16'd1;
            r.new_entry   = 1'b1;
            slots_used++;
        end else begin
            r.table_full = 1'b1;
        end
        r.word_truncated = open_cut;
        word_results.push_back(r);
        open_len = 0;
        open_cut = 1'b0;
        return 1'b1;
    endfunction

    function automatic void count_byte(input t_in_item it);
        bit got;
        got = 1'b0;
        if (it.text_byte == SPACE_BYTE) begin
            got = close_open_word();
        end else if (open_len < MAX_CHARS) begin
            open_chars[open_len] = lower_case(it.text_byte);
            open_len++;
        end else begin
            open_cut = 1'b1;
        end
        if (it.end_of_text) begin
            if (!got) void'(close_open_word());
            open_len   = 0;
            open_cut   = 1'b0;
            slots_used = 0;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eot);
        t_in_item it;
        it.text_byte   = b;
        it.end_of_text = eot;
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_item <= it;
        push   <= 1'b1;
        do @(posedge i_clk); while (full);
        count_byte(it);
        items_sent++;
    endtask

    task automatic send_text(input string s, input bit eot);
        for (int k = 0; k < s.len(); k++)
            send_byte(s[k], eot && (k == s.len() - 1));
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (word_results.size() != 0) @(posedge i_clk);
        repeat (2 * NUM_SLOTS + 20) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("word_frequency_counter_top: mismatch");
            $finish;
        end
    end

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        if (i_rst_n && !empty && pop) begin
            if (word_results.size() == 0) begin
                $error("unexpected transaction: index %0d total %0d",
                       o_result.entry_index, o_result.word_total);
                fail_count++;
            end else begin
                want = word_results.pop_front();
                if (o_result.entry_index !== want.entry_index) begin
                    $error("entry_index: expected %0d, got %0d",
                           want.entry_index, o_result.entry_index);
                    fail_count++;
                end
                if (o_result.word_total !== want.word_total) begin
                    $error("word_total: expected %0d, got %0d",
                           want.word_total, o_result.word_total);
                    fail_count++;
                end
                if (o_result.new_entry !== want.new_entry) begin
                    $error("new_entry: expected %0b, got %0b",
                           want.new_entry, o_result.new_entry);
                    fail_count++;
                end
                if (o_result.table_full !== want.table_full) begin
                    $error("table_full: expected %0b, got %0b",
                           want.table_full, o_result.table_full);
                    fail_count++;
                end
                if (o_result.word_truncated !== want.word_truncated) begin
                    $error("word_truncated: expected %0b, got %0b",
                           want.word_truncated, o_result.word_truncated);
                    fail_count++;
                end
            end
        end
        pop <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic test_directed();
        // case folding, repeated spaces, odd bytes inside words
        send_text("Hello hello  HELLO @[`{ Az", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(SPACE_BYTE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        // end of text on a space and on an empty word
        send_text("zz ", 1'b1);
        send_byte(SPACE_BYTE, 1'b1);
    endtask

    task automatic test_long_words();
        send_text("abcdefghijklmnop abcdefghijklmnopqrstu ABCDEFGHIJKLMNOPQ", 1'b1);
    endtask

    task automatic test_table_full();
        for (int w = 0; w < NUM_SLOTS + 3; w++) begin
            send_byte(8'd97 + w[7:0] % 26, 1'b0);
            send_byte(8'd97 + w[7:0] / 26, 1'b0);
            send_byte(SPACE_BYTE, 1'b0);
        end
        send_text("aa ", 1'b0);
        send_text("xx", 1'b1);
    endtask

    task automatic send_random_word();
        string vocab [12] = '{"the", "cat", "A", "dog", "ran", "over",
                              "it", "wordy", "x", "fast", "and", "to"};
        string w;
        int    pick;
        int    len;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 80) begin
            w = vocab[$urandom_range(11)];
            for (int k = 0; k < w.len(); k++) begin
                b = w[k];
                if (b >= 8'd97 && $urandom_range(1)) b = b - 8'd32;
                send_byte(b, 1'b0);
            end
        end else begin
            len = (pick < 90) ? $urandom_range(1, 24) : $urandom_range(1, 3);
            for (int k = 0; k < len; k++) begin
                do b = 8'($urandom_range(0, 255)); while (b == SPACE_BYTE);
                send_byte(b, 1'b0);
            end
        end
    endtask

    task automatic test_random_text(input int idle_pct, input int stall_pct, input int n);
        int stop_at;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            send_random_word();
            repeat ($urandom_range(1, 2)) send_byte(SPACE_BYTE, 1'b0);
            if ($urandom_range(9) == 0)
                send_byte($urandom_range(1) ? SPACE_BYTE : 8'h61, 1'b1);
        end
        send_byte(8'h62, 1'b1);
    endtask

    initial begin
        fail_count = 0;
        cycle_count = 0;
        items_sent = 0;
        open_len = 0;
        open_cut = 1'b0;
        slots_used = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_long_words();
        test_table_full();
        drain_results();
        test_random_text(0, 0, RAND_ITEMS / 4);
        test_random_text(75, 0, RAND_ITEMS / 4);
        drain_results();
        test_random_text(0, 75, RAND_ITEMS / 4);
        test_random_text(7, 7, RAND_ITEMS / 4);

        drain_results();
        if (fail_count == 0)
            $display("word_frequency_counter_top: match");
        else
            $display("word_frequency_counter_top: mismatch");
        $finish;
    end
endmodule

### filelist.f
rtl/wfc_pkg.sv
rtl/wfc_ram.sv
rtl/wfc_queue.sv
rtl/wfc_front.sv
rtl/wfc_back.sv
rtl/word_frequency_counter_top.sv
rtl/wfc_checker.sv
verif/word_frequency_counter_top_tb.sv
